[rtl/skp_pkg.sv]
// Shared types, constants and the 32-bit saturation helper for the keypoint unprojection core.
package skp_pkg;

  typedef enum logic [0:0] {
    OP_POINT = 1'b0,
    OP_LOAD  = 1'b1
  } opcode_t;

  localparam int POSE_WORDS = 12;
  localparam logic [3:0] POSE_TX = 4'd9;
  localparam logic [3:0] POSE_LAST = 4'd11;

  typedef enum logic [1:0] {
    CFG_CENTER_X    = 2'd0,
    CFG_CENTER_Y    = 2'd1,
    CFG_INV_FOCAL_X = 2'd2,
    CFG_INV_FOCAL_Y = 2'd3
  } cfg_index_t;

  // one classified item waiting for the back end
  typedef struct packed {
    logic        is_load;
    logic [3:0]  idx;
    logic [31:0] value;
    logic [28:0] u;
    logic [28:0] v;
    logic [31:0] depth;
  } item_t;

  // camera-space beat handed to the rigid transform
  typedef struct packed {
    logic        valid;
    logic        is_load;
    logic [3:0]  idx;
    logic [31:0] value;
    logic        ok;
    logic [31:0] cam_x;
    logic [31:0] cam_y;
    logic [31:0] cam_z;
  } cam_t;

  // world-space accumulators before final scaling
  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [66:0] acc_x;
    logic [66:0] acc_y;
    logic [66:0] acc_z;
  } acc_t;

  function automatic logic [31:0] sat32(input logic signed [95:0] a);
    logic hi_ok;
    logic lo_ok;
    hi_ok = (a[95:31] == '0);
    lo_ok = (a[95:31] == '1);
    if (hi_ok || lo_ok) return a[31:0];
    else if (a[95]) return 32'h8000_0000;
    else return 32'h7FFF_FFFF;
  endfunction

endpackage

[rtl/skp_front.sv]
// Front end: accepts input beats, drops bad pose loads, queues items for the back end.
module skp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [0:0]          opcode,
  input  logic [3:0]          pose_index,
  input  logic signed [31:0]  pose_value,
  input  logic [28:0]         pixel_u,
  input  logic [28:0]         pixel_v,
  input  logic signed [31:0]  depth,
  input  logic                pop,
  output logic                head_valid,
  output skp_pkg::item_t      head
);

  localparam int DEPTH = 4;

  skp_pkg::item_t q [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] cnt;
  logic       accept;
  logic       push;
  logic       do_pop;
  skp_pkg::item_t item;

  assign in_stall   = (cnt == 3'(DEPTH));
  assign accept     = in_valid && !in_stall;
  assign head_valid = (cnt != 3'd0);
  assign head       = q[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_comb begin
    item.is_load = (opcode == skp_pkg::OP_LOAD);
    item.idx     = pose_index;
    item.value   = pose_value;
    item.u       = pixel_u;
    item.v       = pixel_v;
    item.depth   = depth;
  end

  // out-of-range pose loads are dropped here
  assign push = accept && !(item.is_load && (pose_index > skp_pkg::POSE_LAST));

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      cnt <= cnt + 3'(push) - 3'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 3'(DEPTH))
    else $error("queue count overflow");

endmodule

[rtl/skp_camera.sv]
// Back-projection pipeline: pixel and depth to camera coordinates, five stages.
module skp_camera #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           item_valid,
  input  skp_pkg::item_t item,
  input  logic [28:0]    center_x,
  input  logic [28:0]    center_y,
  input  logic [31:0]    inv_focal_x,
  input  logic [31:0]    inv_focal_y,
  output skp_pkg::cam_t  cam
);

  localparam int SH = FRAC_BITS + 32;

  typedef struct packed {
    logic        valid;
    logic        is_load;
    logic [3:0]  idx;
    logic [31:0] value;
    logic        ok;
    logic [31:0] z;
  } tag_t;

  tag_t t1, t2, t3, t4;

  logic signed [29:0] dx1, dy1;
  logic signed [61:0] px2, py2;
  logic signed [63:0] hx3, hy3;
  logic signed [64:0] lx3, ly3;
  logic signed [95:0] fx4, fy4;
  logic signed [32:0] ifx, ify;

  assign ifx = $signed({1'b0, inv_focal_x});
  assign ify = $signed({1'b0, inv_focal_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
      t4.valid <= 1'b0;
      cam.valid <= 1'b0;
    end else if (en) begin
      // S1: center offsets, depth sign
      t1.valid   <= item_valid;
      t1.is_load <= item.is_load;
      t1.idx     <= item.idx;
      t1.value   <= item.value;
      t1.ok      <= ($signed(item.depth) > 32'sd0);
      t1.z       <= item.depth;
      dx1 <= $signed({1'b0, item.u}) - $signed({1'b0, center_x});
      dy1 <= $signed({1'b0, item.v}) - $signed({1'b0, center_y});
      // S2: offset times depth
      t2  <= t1;
      px2 <= dx1 * $signed(t1.z);
      py2 <= dy1 * $signed(t1.z);
      // S3: split 62-bit product into two 31-bit halves, each times the inverse focal
      t3  <= t2;
      hx3 <= $signed(px2[61:31]) * ifx;
      lx3 <= $signed({1'b0, px2[30:0]}) * ifx;
      hy3 <= $signed(py2[61:31]) * ify;
      ly3 <= $signed({1'b0, py2[30:0]}) * ify;
      // S4: recombine
      t4  <= t3;
      fx4 <= $signed({hx3[63], hx3, 31'b0}) + $signed({{31{lx3[64]}}, lx3});
      fy4 <= $signed({hy3[63], hy3, 31'b0}) + $signed({{31{ly3[64]}}, ly3});
      // S5: scale and saturate
      cam.valid   <= t4.valid;
      cam.is_load <= t4.is_load;
      cam.idx     <= t4.idx;
      cam.value   <= t4.value;
      cam.ok      <= t4.ok;
      cam.cam_x   <= skp_pkg::sat32(fx4 >>> SH);
      cam.cam_y   <= skp_pkg::sat32(fy4 >>> SH);
      cam.cam_z   <= t4.z;
    end
  end

endmodule

[rtl/skp_world.sv]
// Rigid transform: pose store, offset by translation, rotation transpose multiply and sum.
module skp_world #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  skp_pkg::cam_t cam,
  output skp_pkg::acc_t acc
);

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  logic [31:0] pose [skp_pkg::POSE_WORDS];

  logic               v6, ok6, v7, ok7;
  logic signed [32:0] d6 [3];
  logic signed [64:0] m7 [9];
  logic signed [31:0] cin [3];

  assign cin[0] = $signed(cam.cam_x);
  assign cin[1] = $signed(cam.cam_y);
  assign cin[2] = $signed(cam.cam_z);

  // loads take effect as they enter S6, so older points already read the old pose
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < skp_pkg::POSE_WORDS; k++) begin
        pose[k] <= (k == 0 || k == 4 || k == 8) ? ONE : 32'd0;
      end
    end else if (en && cam.valid && cam.is_load) begin
      for (int k = 0; k < skp_pkg::POSE_WORDS; k++) begin
        if (cam.idx == 4'(k)) pose[k] <= cam.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      acc.valid <= 1'b0;
    end else if (en) begin
      v6 <= cam.valid && !cam.is_load;
      v7 <= v6;
      acc.valid <= v7;
      ok6 <= cam.ok;
      for (int i = 0; i < 3; i++) begin
        d6[i] <= $signed({cin[i][31], cin[i]})
               - $signed({pose[9 + i][31], pose[9 + i]});
      end
      ok7 <= ok6;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m7[i * 3 + j] <= $signed(pose[i * 3 + j]) * d6[i];
        end
      end
      acc.ok <= ok7;
      acc.acc_x <= {{2{m7[0][64]}}, m7[0]} + {{2{m7[3][64]}}, m7[3]}
                 + {{2{m7[6][64]}}, m7[6]};
      acc.acc_y <= {{2{m7[1][64]}}, m7[1]} + {{2{m7[4][64]}}, m7[4]}
                 + {{2{m7[7][64]}}, m7[7]};
      acc.acc_z <= {{2{m7[2][64]}}, m7[2]} + {{2{m7[5][64]}}, m7[5]}
                 + {{2{m7[8][64]}}, m7[8]};
    end
  end

endmodule

[rtl/stereo_keypoint_unprojection_core.sv]
// Top level of the stereo keypoint unprojection core: config, front queue, back pipeline, output.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------
//  input    | in_valid / in_stall | opcode pose_index pose_value pixel_u pixel_v depth
//  output   | out_valid/out_stall | world_x world_y world_z point_valid
//  config   | cfg_we              | cfg_index cfg_data
//
// One item per cycle while the output does not stall; loads and keypoints share the same slot.
// An input beat passes through the queue, the back-projection stages (two-step wide
// multiply), the transform stages and the output register on its way to the output beat.
// Reset restores the identity pose and clears the config registers and all valids.
// A stall on a valid output beat freezes the whole back pipeline; the four-entry queue keeps
// taking input beats until it fills.
module stereo_keypoint_unprojection_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [0:0]         opcode,
  input  logic [3:0]         pose_index,
  input  logic signed [31:0] pose_value,
  input  logic [28:0]        pixel_u,
  input  logic [28:0]        pixel_v,
  input  logic signed [31:0] depth,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] world_x,
  output logic signed [31:0] world_y,
  output logic signed [31:0] world_z,
  output logic               point_valid,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [28:0] center_x, center_y;
  logic [31:0] inv_focal_x, inv_focal_y;

  logic           en;
  logic           head_valid;
  skp_pkg::item_t head;
  skp_pkg::cam_t  cam;
  skp_pkg::acc_t  acc;

  // whole back end advances together unless the output beat is stuck
  assign en = !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      inv_focal_x <= '0;
      inv_focal_y <= '0;
    end else if (cfg_we) begin
      unique case (skp_pkg::cfg_index_t'(cfg_index))
        skp_pkg::CFG_CENTER_X:    center_x    <= cfg_data[28:0];
        skp_pkg::CFG_CENTER_Y:    center_y    <= cfg_data[28:0];
        skp_pkg::CFG_INV_FOCAL_X: inv_focal_x <= cfg_data;
        skp_pkg::CFG_INV_FOCAL_Y: inv_focal_y <= cfg_data;
        default: ;
      endcase
    end
  end

  skp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .pose_index (pose_index),
    .pose_value (pose_value),
    .pixel_u    (pixel_u),
    .pixel_v    (pixel_v),
    .depth      (depth),
    .pop        (en),
    .head_valid (head_valid),
    .head       (head)
  );

  skp_camera #(.FRAC_BITS(FRAC_BITS)) u_camera (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .item_valid  (head_valid),
    .item        (head),
    .center_x    (center_x),
    .center_y    (center_y),
    .inv_focal_x (inv_focal_x),
    .inv_focal_y (inv_focal_y),
    .cam         (cam)
  );

  skp_world #(.FRAC_BITS(FRAC_BITS)) u_world (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .cam (cam),
    .acc (acc)
  );

  // final scale by 2^F and saturate; non-positive depth forces a zero point
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= acc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point_valid <= acc.ok;
      world_x <= acc.ok
               ? skp_pkg::sat32($signed({{29{acc.acc_x[66]}}, acc.acc_x}) >>> FRAC_BITS) : '0;
      world_y <= acc.ok
               ? skp_pkg::sat32($signed({{29{acc.acc_y[66]}}, acc.acc_y}) >>> FRAC_BITS) : '0;
      world_z <= acc.ok
               ? skp_pkg::sat32($signed({{29{acc.acc_z[66]}}, acc.acc_z}) >>> FRAC_BITS) : '0;
    end
  end

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_bad_depth_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !point_valid) |-> (world_x == 0 && world_y == 0 && world_z == 0))
    else $error("invalid point with nonzero coordinates");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> ((cam === $past(cam)) && (acc === $past(acc))))
    else $error("back pipeline moved while output stalled");

endmodule
